@@ hw/rtl/skf_pkg.sv @@
// ----------------------------------------------------------------------------
// skf_pkg: shared types and codes of the scalar Kalman filter unit
// Payload structs, configuration register indexes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MEAN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_VAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_VAR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MOT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MEAS = 3'd5;

    localparam logic [30:0] VAR_RESET = 31'd65536;
    localparam logic [30:0] VAR_MAX   = 31'h7FFF_FFFF;

    typedef struct packed {
        logic               start_req;
        logic signed [31:0] motion;
        logic signed [31:0] measurement;
    } t_in;

    typedef struct packed {
        logic signed [31:0] est_mean;
        logic        [30:0] est_var;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRED,
        S_MUL,
        S_DSET,
        S_DIV,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

@@ hw/rtl/scalar_kalman_filter_unit.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit: one-dimensional Kalman filter, Q16.16
// Predict/correct per transaction, bit-serial multiply and divide.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in  (skf_pkg::t_in)
//  out     | output    | o_out_valid / i_out_ready | o_out (skf_pkg::t_out)
//  cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_wdata
//
//  One predict/correct pass runs predict, multiply, divider setup, divide and
//  finish: the shift-add multiplier walks the 31 variance bits, the restoring
//  divider produces 32 quotient bits. A transaction is accepted in the idle
//  state; a start transaction runs two passes. Reset is synchronous, active
//  low; it clears control and loads register reset values. One transaction
//  is worked at a time; the result register holds a finished result while
//  the next transaction is accepted, and the sequencer waits in its final
//  state only if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire skf_pkg::t_in                  i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output skf_pkg::t_out                      o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [skf_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // configuration
    logic signed [31:0] r_init_mean, r_first_mot, r_first_meas;
    logic        [30:0] r_init_var, r_sensor_var, r_move_var;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_mean  <= '0;
            r_init_var   <= skf_pkg::VAR_RESET;
            r_sensor_var <= skf_pkg::VAR_RESET;
            r_move_var   <= '0;
            r_first_mot  <= '0;
            r_first_meas <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                skf_pkg::CFG_INIT_MEAN:  r_init_mean  <= i_cfg_wdata;
                skf_pkg::CFG_INIT_VAR:   r_init_var   <= i_cfg_wdata[30:0];
                skf_pkg::CFG_SENSOR_VAR: r_sensor_var <= i_cfg_wdata[30:0];
                skf_pkg::CFG_MOVE_VAR:   r_move_var   <= i_cfg_wdata[30:0];
                skf_pkg::CFG_FIRST_MOT:  r_first_mot  <= i_cfg_wdata;
                skf_pkg::CFG_FIRST_MEAS: r_first_meas <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // datapath registers
    skf_pkg::t_state    r_state, n_state;
    logic               r_first, n_first;
    logic signed [31:0] r_motion, n_motion, r_meas, n_meas;
    logic signed [31:0] r_mean, n_mean;
    logic        [30:0] r_var, n_var;
    logic        [31:0] r_den, n_den;
    logic        [30:0] r_msv, n_msv, r_mv, n_mv;      // multiplier bit shifters
    logic signed [63:0] r_acc_num, n_acc_num;
    logic        [61:0] r_acc_var, n_acc_var;
    logic        [31:0] r_rem_num, n_rem_num, r_rem_var, n_rem_var;
    logic        [31:0] r_q_num, n_q_num, r_q_var, n_q_var; // dividend low / quotient
    logic               r_neg, n_neg;
    logic        [4:0]  r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    skf_pkg::t_out      r_out, n_out;

    // combinational helpers
    logic signed [31:0] step, meas_sel;
    logic        [32:0] mean_sum;
    logic        [31:0] var_sum;
    logic signed [31:0] mean_p;
    logic        [30:0] var_p;
    logic        [63:0] num_mag;
    logic        [32:0] t_num, t_var;
    logic               ge_num, ge_var;
    logic        [31:0] q_mean;

    always_comb begin
        step     = r_first ? r_first_mot : r_motion;
        meas_sel = r_first ? r_first_meas : r_meas;
        // saturating predict
        mean_sum = {r_mean[31], r_mean} + {step[31], step};
        if (mean_sum[32] != mean_sum[31]) begin
            mean_p = mean_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            mean_p = mean_sum[31:0];
        end
        var_sum = {1'b0, r_var} + {1'b0, r_move_var};
        var_p   = var_sum[31] ? skf_pkg::VAR_MAX : var_sum[30:0];
        // divider step: shift in next dividend bit, trial subtract
        num_mag = r_acc_num[63] ? (~r_acc_num + 64'd1) : r_acc_num;
        t_num   = {r_rem_num, r_q_num[31]};
        t_var   = {r_rem_var, r_q_var[31]};
        ge_num  = t_num >= {1'b0, r_den};
        ge_var  = t_var >= {1'b0, r_den};
        q_mean  = r_neg ? (~r_q_num + 32'd1) : r_q_num;
    end

    assign o_in_ready  = (r_state == skf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
            r_mean      <= '0;
            r_var       <= skf_pkg::VAR_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
            r_mean      <= n_mean;
            r_var       <= n_var;
        end
    end

    always_ff @(posedge i_clk) begin
        r_motion  <= n_motion;
        r_meas    <= n_meas;
        r_den     <= n_den;
        r_msv     <= n_msv;
        r_mv      <= n_mv;
        r_acc_num <= n_acc_num;
        r_acc_var <= n_acc_var;
        r_rem_num <= n_rem_num;
        r_rem_var <= n_rem_var;
        r_q_num   <= n_q_num;
        r_q_var   <= n_q_var;
        r_neg     <= n_neg;
        r_cnt     <= n_cnt;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_motion    = r_motion;
        n_meas      = r_meas;
        n_mean      = r_mean;
        n_var       = r_var;
        n_den       = r_den;
        n_msv       = r_msv;
        n_mv        = r_mv;
        n_acc_num   = r_acc_num;
        n_acc_var   = r_acc_var;
        n_rem_num   = r_rem_num;
        n_rem_var   = r_rem_var;
        n_q_num     = r_q_num;
        n_q_var     = r_q_var;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            skf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_motion = i_in.motion;
                    n_meas   = i_in.measurement;
                    n_first  = i_in.start_req;
                    if (i_in.start_req) begin
                        n_mean = r_init_mean;
                        n_var  = r_init_var;
                    end
                    n_state = skf_pkg::S_PRED;
                end
            end
            skf_pkg::S_PRED: begin
                n_mean    = mean_p;
                n_var     = var_p;
                n_den     = {1'b0, var_p} + {1'b0, r_sensor_var};
                n_msv     = r_sensor_var;
                n_mv      = var_p;
                n_acc_num = '0;
                n_acc_var = '0;
                n_cnt     = 5'd30;
                n_state   = skf_pkg::S_MUL;
            end
            skf_pkg::S_MUL: begin
                // Horner over the variance bits, MSB first
                n_acc_num = (r_acc_num <<< 1)
                          + (r_msv[30] ? 64'(r_mean) : 64'sd0)
                          + (r_mv[30]  ? 64'(meas_sel) : 64'sd0);
                n_acc_var = (r_acc_var << 1) + (r_msv[30] ? 62'(r_var) : 62'd0);
                n_msv     = r_msv << 1;
                n_mv      = r_mv << 1;
                n_cnt     = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = skf_pkg::S_DSET;
                end
            end
            skf_pkg::S_DSET: begin
                // quotients fit 32 bits, so the upper half starts as remainder
                n_neg     = r_acc_num[63];
                n_rem_num = num_mag[63:32];
                n_q_num   = num_mag[31:0];
                n_rem_var = {2'b00, r_acc_var[61:32]};
                n_q_var   = r_acc_var[31:0];
                n_cnt     = 5'd31;
                n_state   = skf_pkg::S_DIV;
            end
            skf_pkg::S_DIV: begin
                n_rem_num = ge_num ? 32'(t_num - {1'b0, r_den}) : t_num[31:0];
                n_rem_var = ge_var ? 32'(t_var - {1'b0, r_den}) : t_var[31:0];
                n_q_num   = {r_q_num[30:0], ge_num};
                n_q_var   = {r_q_var[30:0], ge_var};
                n_cnt     = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = skf_pkg::S_FIN;
                end
            end
            skf_pkg::S_FIN: begin
                if (r_first) begin
                    n_first = 1'b0;
                    n_state = skf_pkg::S_PRED;
                    if (r_den == 32'd0) begin
                        n_var = '0;
                    end else begin
                        n_mean = q_mean;
                        n_var  = r_q_var[30:0];
                    end
                end else if (!r_out_valid || i_out_ready) begin
                    if (r_den == 32'd0) begin
                        n_var = '0;
                    end else begin
                        n_mean = q_mean;
                        n_var  = r_q_var[30:0];
                    end
                    n_out.est_mean = n_mean;
                    n_out.est_var  = n_var;
                    n_out_valid    = 1'b1;
                    n_state        = skf_pkg::S_IDLE;
                end
            end
            default: n_state = skf_pkg::S_IDLE;
        endcase
    end

    // accepted transaction always starts with a predict
    a_accept_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == skf_pkg::S_PRED))
        else $error("accept did not start predict");

    // multiplier hands over to divider setup after the last bit
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skf_pkg::S_MUL && r_cnt == 5'd0) |=> (r_state == skf_pkg::S_DSET))
        else $error("multiplier did not finish");

    // restoring divider keeps partial remainders below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skf_pkg::S_DIV && r_den != 32'd0)
            |-> (r_rem_var < r_den && r_rem_num < r_den))
        else $error("divider remainder out of range");

    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost");

endmodule

`default_nettype wire

@@ tb/skf_checker.sv @@
// ----------------------------------------------------------------------------
// skf_checker: scoreboard for the scalar Kalman filter unit
// Mirrors the config port, predicts each estimate, compares field by field.
// ----------------------------------------------------------------------------
module skf_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  skf_pkg::t_in                       i_in,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  skf_pkg::t_out                      i_out,
    input  logic                               i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [skf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    localparam longint MEAN_HI = 64'sd2147483647;
    localparam longint MEAN_LO = -64'sd2147483648;
    localparam longint VAR_HI  = 64'sd2147483647;

    longint        cfg_mean0, cfg_var0, cfg_sensor, cfg_move, cfg_mot0, cfg_meas0;
    longint        est_m, est_v;
    skf_pkg::t_out estimates_q[$];

    function automatic longint sx(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic void kalman_update(longint step, longint meas);
        longint m, v, den;
        m = est_m + step;
        v = est_v + cfg_move;
        if (m > MEAN_HI) m = MEAN_HI;
        if (m < MEAN_LO) m = MEAN_LO;
        if (v > VAR_HI) v = VAR_HI;
        den = v + cfg_sensor;
        if (den == 0) begin
            est_m = m;
            est_v = 0;
        end else begin
            est_m = (cfg_sensor * m + v * meas) / den;  // truncates toward zero
            est_v = (v * cfg_sensor) / den;
        end
    endfunction

    always @(posedge i_clk) begin
        skf_pkg::t_out exp_r;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            cfg_mean0 = 0; cfg_var0 = 65536; cfg_sensor = 65536;
            cfg_move = 0; cfg_mot0 = 0; cfg_meas0 = 0;
            est_m = 0; est_v = 65536;
            estimates_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    skf_pkg::CFG_INIT_MEAN:  cfg_mean0  = sx(i_cfg_wdata);
                    skf_pkg::CFG_INIT_VAR:   cfg_var0   = longint'(i_cfg_wdata[30:0]);
                    skf_pkg::CFG_SENSOR_VAR: cfg_sensor = longint'(i_cfg_wdata[30:0]);
                    skf_pkg::CFG_MOVE_VAR:   cfg_move   = longint'(i_cfg_wdata[30:0]);
                    skf_pkg::CFG_FIRST_MOT:  cfg_mot0   = sx(i_cfg_wdata);
                    skf_pkg::CFG_FIRST_MEAS: cfg_meas0  = sx(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (estimates_q.size() == 0) begin
                    $display("%0t: unexpected result mean=%0d var=%0d", $time,
                             i_out.est_mean, i_out.est_var);
                    errs++;
                end else begin
                    exp_r = estimates_q.pop_front();
                    if (exp_r.est_mean !== i_out.est_mean) begin
                        $display("%0t: est_mean expected %0d actual %0d", $time,
                                 exp_r.est_mean, i_out.est_mean);
                        errs++;
                    end
                    if (exp_r.est_var !== i_out.est_var) begin
                        $display("%0t: est_var expected %0d actual %0d", $time,
                                 exp_r.est_var, i_out.est_var);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in.start_req) begin
                    est_m = cfg_mean0;
                    est_v = cfg_var0;
                    kalman_update(cfg_mot0, cfg_meas0);
                end
                kalman_update(sx(i_in.motion), sx(i_in.measurement));
                exp_r.est_mean = est_m[31:0];
                exp_r.est_var  = est_v[30:0];
                estimates_q = {estimates_q, exp_r};
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= estimates_q.size();
    end
endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: top of the scalar Kalman filter unit testbench
// Drives config phases, directed and random transactions with random gaps
// and output stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           in_valid, in_ready;
    skf_pkg::t_in                   in_data;
    logic                           out_valid, out_ready;
    skf_pkg::t_out                  out_data;
    logic                           cfg_we;
    logic [skf_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [skf_pkg::CFG_DATA_W-1:0] cfg_wdata;
    int                             fail_count, pending;
    bit                             calm;    // no idling on either side while set

    scalar_kalman_filter_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    skf_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop: ends a hung run with a failure.
    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    // Output side: per result a random stall, none while calm.
    initial begin
        int stall;
        out_ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    // One input transaction; valid stays high across back-to-back items.
    task automatic send(bit st, logic [31:0] mot, logic [31:0] meas);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{start_req: st, motion: mot, measurement: meas};
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Writes one full register set, only with the block idle.
    task automatic load_cfg(logic [31:0] m0, logic [31:0] v0, logic [31:0] sv,
                            logic [31:0] mv, logic [31:0] mot0, logic [31:0] meas0);
        logic [31:0] vals[6];
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        vals = '{m0, v0, sv, mv, mot0, meas0};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= skf_pkg::CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly realistic magnitudes, some full-range and boundary values.
    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
        endcase
    endfunction

    function automatic logic [31:0] pick_var();
        case ($urandom_range(0, 7))
            0: return 32'd1;
            1: return 32'h7FFF_FFFF;
            2: return {1'b0, 31'($urandom_range(0, 32'h7FFF_FFFF))};
            default: return $urandom_range(1, 32'h0010_0000);
        endcase
    endfunction

    initial begin
        int n;
        i_rst_n   = 0;
        in_valid  = 0;
        in_data   = '0;
        cfg_we    = 0;
        cfg_idx   = '0;
        cfg_wdata = '0;
        calm      = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset defaults: plain items, start, saturating motions.
        send(0, 32'h0001_0000, 32'h0002_0000);
        send(1, 32'h0000_0000, 32'h0000_0000);
        send(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(0, 32'h8000_0000, 32'h8000_0000);
        send(0, 32'h8000_0000, 32'h8000_0000);
        send(0, 32'hFFFF_FFFF, 32'h0000_0001);
        send(1, 32'h5555_5555, 32'hAAAA_AAAA);
        send(0, 32'hAAAA_AAAA, 32'h5555_5555);

        // Extremes: largest variances saturate on predict.
        load_cfg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000);
        send(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(0, 32'h8000_0000, 32'h8000_0000);
        send(1, 32'h0000_0000, 32'h7FFF_FFFF);

        // Smallest variances: variance truncates to zero.
        load_cfg(32'h8000_0000, 32'd1, 32'd1, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send(1, 32'h8000_0000, 32'h8000_0000);
        send(0, 32'h0000_0001, 32'hFFFF_FFFF);
        send(0, 32'h7FFF_FFFF, 32'h0000_0000);
        send(1, 32'h0000_0000, 32'h0000_0000);
        send(0, 32'h1234_5678, 32'h8765_4321);

        // Random phases, each with fresh config; mostly ongoing tracking.
        for (int ph = 0; ph < 6; ph++) begin
            load_cfg(pick_pos(), pick_var(), pick_var(), ($urandom_range(0, 3) == 0) ?
                     32'd0 : pick_var(), pick_pos(), pick_pos());
            n = 150;
            for (int k = 0; k < n; k++) begin
                if (k % 50 == 0) calm = ($urandom_range(0, 2) == 0);
                send(k == 0 || $urandom_range(0, 19) == 0, pick_pos(), pick_pos());
            end
            calm = 0;
        end
        in_valid <= 1'b0;

        @(posedge i_clk);
        n = 0;
        while (pending != 0 && n < 100_000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
